>>> sv/tpr_pkg.sv
package tpr_pkg;

    // Curve table size and the widths that follow from it
    localparam int CURVE_TABLE_DEPTH = 256;
    localparam int CURVE_IDX_W       = $clog2(CURVE_TABLE_DEPTH);
    localparam int CURVE_W           = 17;
    localparam int DEPTH_SQ          = CURVE_TABLE_DEPTH * CURVE_TABLE_DEPTH;

    // Datapath widths
    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int DELTA_W = 33;
    localparam int ACC_W   = 52;
    localparam int CNT_W   = 5;

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned EXP_M1_Q30 = 64'd395007542;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET_ABS = 2'd1,
        CMD_SET_REL = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic {
        CFG_PING_PONG  = 1'b0,
        CFG_CURVE_MODE = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_DIV_STEP,
        OP_MUL_STEP,
        OP_SHR16
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    mul_bit;
    } alu_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SET_A,
        ST_SET_B,
        ST_SET_C,
        ST_SET_D,
        ST_SET_E,
        ST_TURN_A,
        ST_TURN_B,
        ST_TURN_C,
        ST_TURN_D,
        ST_SPAN_A,
        ST_SPAN_B,
        ST_DELTA_A,
        ST_DELTA_B,
        ST_ELAP_A,
        ST_ELAP_B,
        ST_CHECK,
        ST_DIV,
        ST_DIV_END,
        ST_ROM,
        ST_MUL_A,
        ST_MUL,
        ST_RND,
        ST_SHR,
        ST_BASE,
        ST_POS,
        ST_FINISH
    } state_t;

    typedef logic [CURVE_TABLE_DEPTH-1:0][CURVE_W-1:0] curve_rom_t;

    // Rising half of a bell: round(65536 * exp(-8 * (1 - k/D)^2)), integer exact
    function automatic logic [CURVE_W-1:0] bell_entry(int unsigned k);
        longint unsigned m;
        longint unsigned y;
        longint unsigned n;
        longint unsigned r;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        int              i;
        int              j;
        m    = longint'(CURVE_TABLE_DEPTH) - longint'(k);
        y    = (64'd8 * m * m * Q30_ONE) / DEPTH_SQ;
        n    = y >> 30;
        r    = y & (Q30_ONE - 64'd1);
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (i = 1; i <= 16; i++)
        begin
            term = ((term * r) >> 30) / 64'(i);
            if (i[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        v = (sum > 0) ? longint'(sum) : 64'd0;
        for (j = 0; j < 8; j++)
        begin
            if (64'(j) < n)
                v = (v * EXP_M1_Q30) >> 30;
        end
        return CURVE_W'((v + 64'd8192) >> 14);
    endfunction

    function automatic curve_rom_t build_curve_rom();
        curve_rom_t rom;
        int k;
        for (k = 0; k < CURVE_TABLE_DEPTH; k++)
        begin
            rom[k] = bell_entry(k);
        end
        return rom;
    endfunction

endpackage

>>> sv/tpr_alu.sv
module tpr_alu
    import tpr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  alu_ctrl_t               ctrl,
    input  logic signed [ACC_W-1:0] arg,
    output logic signed [ACC_W-1:0] acc,
    output logic [FRAC_W-1:0]       quot
);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [FRAC_W-1:0]       quot_reg, quot_next;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] opa;
    logic signed [ACC_W-1:0] opb;
    logic                    cin;
    logic signed [ACC_W-1:0] sum;

    assign shifted = acc_reg <<< 1;

    // One adder shared by the add, subtract, divide-step and multiply-step operations
    always_comb
    begin
        opa = acc_reg;
        opb = '0;
        cin = 1'b0;
        case (ctrl.op)
            OP_ADD:
            begin
                opb = arg;
            end
            OP_SUB:
            begin
                opb = ~arg;
                cin = 1'b1;
            end
            OP_DIV_STEP:
            begin
                opa = shifted;
                opb = ~arg;
                cin = 1'b1;
            end
            OP_MUL_STEP:
            begin
                opa = shifted;
                opb = ctrl.mul_bit ? arg : '0;
            end
            default:
            begin
                opb = '0;
            end
        endcase
        sum = opa + opb + ACC_W'(cin);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        quot_next = quot_reg;
        case (ctrl.op)
            OP_LOAD:
                acc_next = arg;
            OP_ADD, OP_SUB, OP_MUL_STEP:
                acc_next = sum;
            OP_DIV_STEP:
            begin
                // restoring step: keep the difference only when it is not negative
                acc_next  = sum[ACC_W-1] ? shifted : sum;
                quot_next = {quot_reg[FRAC_W-2:0], ~sum[ACC_W-1]};
            end
            OP_SHR16:
                acc_next = acc_reg >>> FRAC_W;
            default:
                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            quot_reg <= quot_next;
        end
    end

    assign acc  = acc_reg;
    assign quot = quot_reg;

endmodule

>>> sv/tpr_curve_rom.sv
module tpr_curve_rom
    import tpr_pkg::*;
(
    input  logic               clk,
    input  logic [FRAC_W-1:0]  frac,
    output logic [CURVE_W-1:0] level
);

    localparam curve_rom_t CURVE_ROM = build_curve_rom();

    logic [CURVE_IDX_W+FRAC_W-1:0] scaled;
    logic [CURVE_IDX_W-1:0]        idx;
    logic [CURVE_W-1:0]            level_reg;

    // index = frac * depth / 65536, always below the depth
    assign scaled = (CURVE_IDX_W+FRAC_W)'(frac) * (CURVE_IDX_W+FRAC_W)'(CURVE_TABLE_DEPTH);
    assign idx    = scaled[CURVE_IDX_W+FRAC_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        level_reg <= CURVE_ROM[idx];
    end

    assign level = level_reg;

endmodule

>>> sv/timed_position_ramp_unit.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: time_ms, goal_pos, duration_ms; s_tuser: cmd
// m_        out  m_tvalid/m_tready  m_tdata: position, reached, finished
// cfg_      in   cfg_we             cfg_index, cfg_data (ping_pong, curve_mode)
//
// Per item, from accept to ready again: a set adds duration to now (and the offset
// for a relative goal), a snapping tick may make a ping-pong turn, an interpolating
// tick runs the 17 multiply steps on the single shared adder, after 16 divide steps if not clamped.
// Reset: position 0, ramp finished, both mode registers 0; no clearing pass.
// A result waits in the output register while the next item is accepted; the
// sequencer stalls only at its last state if that register is still full.
module timed_position_ramp_unit
    import tpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // [31:0] time_ms, [63:32] goal_pos, [95:64] duration_ms
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] position, [32] reached, [33] finished, zero pad
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    localparam logic [CNT_W-1:0]  DIV_LAST_CNT = CNT_W'(FRAC_W - 1);
    localparam logic [CNT_W-1:0]  MUL_LAST_CNT = CNT_W'(CURVE_W - 1);
    localparam logic [FRAC_W-1:0] FRAC_MAX     = '1;
    localparam int                HALF_LSB     = 32768;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    cmd_t                      cmd_reg, cmd_next;
    logic [TIME_W-1:0]         now_reg, now_next;
    logic signed [POS_W-1:0]   goal_reg, goal_next;
    logic [TIME_W-1:0]         dur_reg, dur_next;
    logic signed [POS_W-1:0]   cur_pos_reg, cur_pos_next;
    logic signed [POS_W-1:0]   start_pos_reg, start_pos_next;
    logic signed [POS_W-1:0]   target_pos_reg, target_pos_next;
    logic [TIME_W-1:0]         start_time_reg, start_time_next;
    logic [TIME_W-1:0]         end_time_reg, end_time_next;
    logic                      done_reg, done_next;
    logic [TIME_W-1:0]         span_reg, span_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic [FRAC_W-1:0]         rt_reg, rt_next;
    logic                      reached_reg, reached_next;
    logic                      ping_pong_reg, ping_pong_next;
    logic                      curve_mode_reg, curve_mode_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic                      out_reached_reg, out_reached_next;
    logic                      out_finished_reg, out_finished_next;

    alu_ctrl_t                 alu_ctrl;
    logic signed [ACC_W-1:0]   alu_arg;
    logic signed [ACC_W-1:0]   acc;
    logic [FRAC_W-1:0]         quot;
    logic [CURVE_W-1:0]        curve_level;
    logic [CURVE_W-1:0]        weight;
    logic signed [POS_W-1:0]   acc_sat;
    logic                      in_xfer;

    tpr_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (alu_ctrl),
        .arg   (alu_arg),
        .acc   (acc),
        .quot  (quot)
    );

    tpr_curve_rom u_curve_rom (
        .clk   (clk),
        .frac  (rt_reg),
        .level (curve_level)
    );

    assign in_xfer = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Weight applied to delta: the ramp fraction itself or the eased level
    assign weight = curve_mode_reg ? curve_level : CURVE_W'(rt_reg);

    // Clamp the accumulator to the signed 32-bit position range
    always_comb
    begin
        if (acc > ACC_W'(signed'(32'sh7FFF_FFFF)))
            acc_sat = 32'sh7FFF_FFFF;
        else if (acc < ACC_W'(signed'(32'sh8000_0000)))
            acc_sat = 32'sh8000_0000;
        else
            acc_sat = acc[POS_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        cmd_next          = cmd_reg;
        now_next          = now_reg;
        goal_next         = goal_reg;
        dur_next          = dur_reg;
        cur_pos_next      = cur_pos_reg;
        start_pos_next    = start_pos_reg;
        target_pos_next   = target_pos_reg;
        start_time_next   = start_time_reg;
        end_time_next     = end_time_reg;
        done_next         = done_reg;
        span_next         = span_reg;
        delta_next        = delta_reg;
        rt_next           = rt_reg;
        reached_next      = reached_reg;
        ping_pong_next    = ping_pong_reg;
        curve_mode_next   = curve_mode_reg;
        out_valid_next    = out_valid_reg;
        out_pos_next      = out_pos_reg;
        out_reached_next  = out_reached_reg;
        out_finished_next = out_finished_reg;
        alu_ctrl.op       = OP_HOLD;
        alu_ctrl.mul_bit  = 1'b0;
        alu_arg           = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PING_PONG:  ping_pong_next  = cfg_data;
                CFG_CURVE_MODE: curve_mode_next = cfg_data;
                default:        ping_pong_next  = ping_pong_reg;
            endcase
        end

        // drop the result once the sink takes it
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next     = cmd_t'(s_tuser);
                    now_next     = s_tdata[31:0];
                    goal_next    = signed'(s_tdata[63:32]);
                    dur_next     = s_tdata[95:64];
                    reached_next = 1'b0;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (cmd_reg)
                    CMD_SET_ABS, CMD_SET_REL:
                        state_next = ST_SET_A;
                    CMD_TICK:
                    begin
                        if (now_reg >= end_time_reg)
                        begin
                            // snap to the goal, then turn around or finish
                            cur_pos_next = target_pos_reg;
                            if (ping_pong_reg)
                                state_next = ST_TURN_A;
                            else
                            begin
                                done_next    = 1'b1;
                                reached_next = 1'b1;
                                state_next   = ST_FINISH;
                            end
                        end
                        else
                            state_next = ST_SPAN_A;
                    end
                    default:
                        state_next = ST_FINISH;
                endcase
            end

            // set: end time = now + duration, goal absolute or saturated offset
            ST_SET_A:
            begin
                alu_ctrl.op = OP_LOAD;
                alu_arg     = ACC_W'(now_reg);
                state_next  = ST_SET_B;
            end
            ST_SET_B:
            begin
                alu_ctrl.op = OP_ADD;
                alu_arg     = ACC_W'(dur_reg);
                state_next  = ST_SET_C;
            end
            ST_SET_C:
            begin
                end_time_next   = acc[TIME_W-1:0];
                start_time_next = now_reg;
                start_pos_next  = cur_pos_reg;
                done_next       = 1'b0;
                if (cmd_reg == CMD_SET_REL)
                begin
                    alu_ctrl.op = OP_LOAD;
                    alu_arg     = ACC_W'(cur_pos_reg);
                    state_next  = ST_SET_D;
                end
                else
                begin
                    target_pos_next = goal_reg;
                    state_next      = ST_FINISH;
                end
            end
            ST_SET_D:
            begin
                alu_ctrl.op = OP_ADD;
                alu_arg     = ACC_W'(goal_reg);
                state_next  = ST_SET_E;
            end
            ST_SET_E:
            begin
                target_pos_next = acc_sat;
                state_next      = ST_FINISH;
            end

            // ping-pong turn: next window ends at 2*end - start, endpoints swap
            ST_TURN_A:
            begin
                alu_ctrl.op = OP_LOAD;
                alu_arg     = ACC_W'(end_time_reg);
                state_next  = ST_TURN_B;
            end
            ST_TURN_B:
            begin
                alu_ctrl.op = OP_SUB;
                alu_arg     = ACC_W'(start_time_reg);
                state_next  = ST_TURN_C;
            end
            ST_TURN_C:
            begin
                alu_ctrl.op = OP_ADD;
                alu_arg     = ACC_W'(end_time_reg);
                state_next  = ST_TURN_D;
            end
            ST_TURN_D:
            begin
                start_time_next = end_time_reg;
                end_time_next   = acc[TIME_W-1:0];
                start_pos_next  = target_pos_reg;
                target_pos_next = start_pos_reg;
                state_next      = ST_FINISH;
            end

            // interpolation: span, delta and elapsed time first
            ST_SPAN_A:
            begin
                alu_ctrl.op = OP_LOAD;
                alu_arg     = ACC_W'(end_time_reg);
                state_next  = ST_SPAN_B;
            end
            ST_SPAN_B:
            begin
                alu_ctrl.op = OP_SUB;
                alu_arg     = ACC_W'(start_time_reg);
                state_next  = ST_DELTA_A;
            end
            ST_DELTA_A:
            begin
                span_next   = acc[TIME_W-1:0];
                alu_ctrl.op = OP_LOAD;
                alu_arg     = ACC_W'(target_pos_reg);
                state_next  = ST_DELTA_B;
            end
            ST_DELTA_B:
            begin
                alu_ctrl.op = OP_SUB;
                alu_arg     = ACC_W'(start_pos_reg);
                state_next  = ST_ELAP_A;
            end
            ST_ELAP_A:
            begin
                delta_next  = acc[DELTA_W-1:0];
                alu_ctrl.op = OP_LOAD;
                alu_arg     = ACC_W'(now_reg);
                state_next  = ST_ELAP_B;
            end
            ST_ELAP_B:
            begin
                alu_ctrl.op = OP_SUB;
                alu_arg     = ACC_W'(start_time_reg);
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                // before the window: zero; elapsed not below span: clamp
                if (now_reg <= start_time_reg)
                begin
                    rt_next    = '0;
                    state_next = ST_ROM;
                end
                else if (acc[TIME_W-1:0] >= span_reg)
                begin
                    rt_next    = FRAC_MAX;
                    state_next = ST_ROM;
                end
                else
                begin
                    cnt_next   = DIV_LAST_CNT;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle of (elapsed << 16) / span
                alu_ctrl.op = OP_DIV_STEP;
                alu_arg     = ACC_W'(span_reg);
                if (cnt_reg == '0)
                    state_next = ST_DIV_END;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DIV_END:
            begin
                rt_next    = quot;
                state_next = ST_ROM;
            end
            ST_ROM:
            begin
                // wait for the registered curve lookup
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                alu_ctrl.op = OP_LOAD;
                alu_arg     = '0;
                cnt_next    = MUL_LAST_CNT;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                // shift-add delta * weight, weight MSB first
                alu_ctrl.op      = OP_MUL_STEP;
                alu_ctrl.mul_bit = weight[cnt_reg];
                alu_arg          = ACC_W'(delta_reg);
                if (cnt_reg == '0)
                    state_next = ST_RND;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_RND:
            begin
                alu_ctrl.op = OP_ADD;
                alu_arg     = ACC_W'(HALF_LSB);
                state_next  = ST_SHR;
            end
            ST_SHR:
            begin
                alu_ctrl.op = OP_SHR16;
                state_next  = ST_BASE;
            end
            ST_BASE:
            begin
                alu_ctrl.op = OP_ADD;
                alu_arg     = ACC_W'(start_pos_reg);
                state_next  = ST_POS;
            end
            ST_POS:
            begin
                cur_pos_next = acc_sat;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold here until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next    = 1'b1;
                    out_pos_next      = cur_pos_reg;
                    out_reached_next  = reached_reg;
                    out_finished_next = done_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            cmd_reg          <= CMD_TICK;
            now_reg          <= '0;
            goal_reg         <= '0;
            dur_reg          <= '0;
            cur_pos_reg      <= '0;
            start_pos_reg    <= '0;
            target_pos_reg   <= '0;
            start_time_reg   <= '0;
            end_time_reg     <= '0;
            done_reg         <= 1'b1;
            span_reg         <= '0;
            delta_reg        <= '0;
            rt_reg           <= '0;
            reached_reg      <= 1'b0;
            ping_pong_reg    <= 1'b0;
            curve_mode_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_pos_reg      <= '0;
            out_reached_reg  <= 1'b0;
            out_finished_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            cmd_reg          <= cmd_next;
            now_reg          <= now_next;
            goal_reg         <= goal_next;
            dur_reg          <= dur_next;
            cur_pos_reg      <= cur_pos_next;
            start_pos_reg    <= start_pos_next;
            target_pos_reg   <= target_pos_next;
            start_time_reg   <= start_time_next;
            end_time_reg     <= end_time_next;
            done_reg         <= done_next;
            span_reg         <= span_next;
            delta_reg        <= delta_next;
            rt_reg           <= rt_next;
            reached_reg      <= reached_next;
            ping_pong_reg    <= ping_pong_next;
            curve_mode_reg   <= curve_mode_next;
            out_valid_reg    <= out_valid_next;
            out_pos_reg      <= out_pos_next;
            out_reached_reg  <= out_reached_next;
            out_finished_reg <= out_finished_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_finished_reg, out_reached_reg, out_pos_reg};

endmodule

>>> tb/tb_timed_position_ramp_unit.sv
`timescale 1ns / 100ps

module tb_timed_position_ramp_unit;
    import tpr_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 400000;
    // Receiver hold-off long enough to back up the output register and the sequencer
    localparam int unsigned LONG_HOLD     = 300;
    // Settling time given to the block after the last result is back
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam longint unsigned Q30       = 64'd1 << 30;
    localparam longint unsigned INV_E_Q30 = 64'd395007542;

    // Result fields as the checker predicts them
    typedef struct packed {
        logic [31:0] position;
        logic        reached;
        logic        finished;
    } ramp_result_t;

    // Tracks the ramp state, predicts one result per accepted command and
    // checks each result against the oldest prediction.
    class ramp_checker;
        bit             ping_pong_on;
        bit             eased;
        logic [16:0]    ease_rom [CURVE_TABLE_DEPTH];
        longint         cur_pos;
        longint         from_pos;
        longint         to_pos;
        logic [31:0]    win_start;
        logic [31:0]    win_end;
        bit             idle_flag;
        ramp_result_t   expected_results[$];
        int unsigned    fail_count;

        function new();
            for (int k = 0; k < CURVE_TABLE_DEPTH; k++)
                ease_rom[k] = ease_sample(k);
            ping_pong_on = 0;
            eased        = 0;
            cur_pos      = 0;
            from_pos     = 0;
            to_pos       = 0;
            win_start    = '0;
            win_end      = '0;
            idle_flag    = 1;
            fail_count   = 0;
        endfunction

        // exp(-8 * (1 - k/D)^2) in Q16, built from Q30 integer steps:
        // series for the fractional exponent, then whole powers of 1/e
        function logic [16:0] ease_sample(int k);
            longint unsigned m;
            longint unsigned y;
            longint unsigned whole;
            longint unsigned rem;
            longint unsigned term;
            longint unsigned acc;
            longint          series;
            m      = CURVE_TABLE_DEPTH - k;
            y      = (64'd8 * m * m * Q30) / (CURVE_TABLE_DEPTH * CURVE_TABLE_DEPTH);
            whole  = y >> 30;
            rem    = y & (Q30 - 1);
            term   = Q30;
            series = Q30;
            for (int i = 1; i <= 16; i++)
            begin
                term = ((term * rem) >> 30) / i;
                if (i % 2 == 1)
                    series = series - longint'(term);
                else
                    series = series + longint'(term);
            end
            acc = (series > 0) ? series : 0;
            for (longint unsigned i = 0; i < whole; i++)
                acc = (acc * INV_E_Q30) >> 30;
            acc = (acc + 64'd8192) >> 14;
            return acc[16:0];
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Advance the ramp by one command and return the result it produces
        function ramp_result_t advance_ramp(cmd_t op, logic [31:0] now,
                                            logic [31:0] goal, logic [31:0] dur);
            ramp_result_t     res;
            longint           target;
            longint           diff;
            longint           weight;
            longint           prod;
            longint unsigned  elapsed;
            longint unsigned  span;
            longint unsigned  frac;
            longint unsigned  idx;
            logic [31:0]      gap32;
            logic [31:0]      old_end;
            bit               hit;
            hit = 0;
            case (op)
                CMD_SET_ABS, CMD_SET_REL:
                begin
                    if (op == CMD_SET_REL)
                        target = clamp32(cur_pos + longint'($signed(goal)));
                    else
                        target = longint'($signed(goal));
                    from_pos  = cur_pos;
                    to_pos    = target;
                    win_start = now;
                    win_end   = now + dur;
                    idle_flag = 0;
                end
                CMD_TICK:
                begin
                    if (now >= win_end)
                    begin
                        cur_pos = to_pos;
                        if (ping_pong_on)
                        begin
                            // swap the endpoints and open an equal window
                            target    = to_pos;
                            to_pos    = from_pos;
                            from_pos  = target;
                            old_end   = win_end;
                            win_end   = win_end + (win_end - win_start);
                            win_start = old_end;
                        end
                        else
                        begin
                            idle_flag = 1;
                            hit       = 1;
                        end
                    end
                    else
                    begin
                        frac = 0;
                        diff = to_pos - from_pos;
                        if (now > win_start)
                        begin
                            gap32   = now - win_start;
                            elapsed = gap32;
                            gap32   = win_end - win_start;
                            span    = gap32;
                            frac    = (elapsed << 16) / span;
                            if (frac > 65535)
                                frac = 65535;
                        end
                        if (eased)
                        begin
                            idx    = (frac * CURVE_TABLE_DEPTH) >> 16;
                            weight = ease_rom[idx];
                        end
                        else
                            weight = frac;
                        prod    = diff * weight + 32768;
                        cur_pos = clamp32(from_pos + (prod >>> 16));
                    end
                end
                default: ;
            endcase
            res.position = cur_pos[31:0];
            res.reached  = hit;
            res.finished = idle_flag;
            return res;
        endfunction

        function void accept_command(cmd_t op, logic [31:0] now,
                                     logic [31:0] goal, logic [31:0] dur);
            expected_results.push_back(advance_ramp(op, now, goal, dur));
        endfunction

        function void check_result(logic [39:0] word);
            ramp_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, word);
                fail_count++;
                return;
            end
            want = expected_results.pop_front();
            if (word[31:0] !== want.position)
            begin
                $display("%0t: position expected %h actual %h",
                         $time, want.position, word[31:0]);
                fail_count++;
            end
            if (word[32] !== want.reached)
            begin
                $display("%0t: reached expected %b actual %b", $time, want.reached, word[32]);
                fail_count++;
            end
            if (word[33] !== want.finished)
            begin
                $display("%0t: finished expected %b actual %b",
                         $time, want.finished, word[33]);
                fail_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;     // [31:0] time_ms, [63:32] goal_pos, [95:64] duration_ms
    logic [1:0]  s_tuser;     // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // [31:0] position, [32] reached, [33] finished
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_data;

    ramp_checker tracker;
    int unsigned items_sent;
    int unsigned source_calm;
    int unsigned sink_calm;
    bit          hold_request;

    timed_position_ramp_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Random idle gap per transfer, with occasional calm stretches of no idling
    function automatic int unsigned pick_gap(ref int unsigned calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Offer one command and hold it until the block takes the transfer;
    // valid stays high afterwards so back-to-back commands need no extra step
    task automatic send_item(cmd_t op, logic [31:0] now, logic [31:0] goal,
                             logic [31:0] dur);
        int unsigned gap;
        gap = pick_gap(source_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dur, goal, now};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.accept_command(op, now, goal, dur);
        if (op != CMD_NONE)
            items_sent++;
    endtask

    // Stop offering, wait for every outstanding result, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both mode registers; call only with the block drained
    task automatic set_modes(bit pp, bit curve);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PING_PONG;
        cfg_data  <= pp;
        @(posedge clk);
        cfg_index <= CFG_CURVE_MODE;
        cfg_data  <= curve;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.ping_pong_on = pp;
        tracker.eased        = curve;
    endtask

    // One set command followed by a run of ticks that walk through the window
    // and, in ping-pong mode, across several turns
    task automatic run_ramp_sequence();
        logic [31:0] now;
        logic [31:0] t0;
        logic [31:0] dur;
        logic [31:0] goal;
        cmd_t        kind;
        int unsigned n_ticks;
        kind = $urandom_range(0, 1) ? CMD_SET_ABS : CMD_SET_REL;
        now  = $urandom;
        case ($urandom_range(0, 9))
            0:       dur = $urandom;
            1:       dur = '0;
            2, 3:    dur = $urandom_range(1, 16);
            default: dur = $urandom_range(17, 5000);
        endcase
        case ($urandom_range(0, 5))
            0:       goal = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2:    goal = $urandom;
            default: goal = $urandom_range(0, 2 ** 21) - 2 ** 20;
        endcase
        send_item(kind, now, goal, dur);
        t0      = now;
        n_ticks = $urandom_range(3, 12);
        for (int j = 0; j < n_ticks; j++)
        begin
            case ($urandom_range(0, 9))
                0:       now = now - $urandom_range(0, 5);     // step back in time
                1:       now = t0 + dur;                       // land on the goal time
                2:       now = t0 + dur - 1;                   // one before the goal time
                default: now = now + $urandom_range(0, dur / 3 + 1);
            endcase
            send_item(CMD_TICK, now, $urandom, $urandom);
        end
    endtask

    // Mostly well-formed ramps with random content, the rest raw noise
    task automatic run_random_phase(int unsigned count);
        int unsigned stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 8)
                run_ramp_sequence();
            else
                repeat ($urandom_range(1, 3))
                    send_item(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end
    endtask

    // Result side: draw a stall per transfer, or hold off for a long stretch
    // when asked, and check every result that the block hands over
    initial
    begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 0;
            end
            else
                stall = pick_gap(sink_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            tracker.check_result(m_tdata);
        end
    end

    // Bound the run; a hang anywhere ends here
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        tracker      = new();
        items_sent   = 0;
        source_calm  = 0;
        sink_calm    = 0;
        hold_request = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_TICK;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_PING_PONG;
        cfg_data  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: modes at their reset values (no ping-pong, linear)
        send_item(CMD_NONE, '1, '1, '1);                             // unused command, idle state
        send_item(CMD_TICK, '0, '0, '0);                             // tick at time 0 snaps to 0
        send_item(CMD_SET_ABS, 32'd100, 32'h7FFF_FFFF, 32'd1000);
        send_item(CMD_TICK, 32'd50, '0, '0);                         // before the window
        send_item(CMD_TICK, 32'd100, '0, '0);                        // at the window start
        send_item(CMD_TICK, 32'd600, '0, '0);
        send_item(CMD_TICK, 32'd1099, '0, '0);
        send_item(CMD_TICK, 32'd1100, '0, '0);                       // snap, reached
        send_item(CMD_TICK, 32'd1200, '0, '0);                       // tick after finishing
        send_item(CMD_SET_REL, 32'd2000, 32'h7FFF_FFFF, '0);         // saturate high
        send_item(CMD_TICK, 32'd2000, '0, '0);
        send_item(CMD_SET_ABS, 32'd3000, 32'h8000_0000, 32'd10);
        send_item(CMD_TICK, 32'd3005, '0, '0);
        send_item(CMD_TICK, 32'd3010, '0, '0);
        send_item(CMD_SET_REL, 32'hFFFF_FFF0, 32'h8000_0000, 32'h20); // saturate low, end wraps
        send_item(CMD_TICK, 32'hFFFF_FFFF, '0, '0);
        send_item(CMD_SET_ABS, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF);
        send_item(CMD_TICK, '0, '0, '0);
        send_item(CMD_TICK, 32'h7FFF_FFFF, '0, '0);

        // Directed: ping-pong with the eased curve
        drain_results();
        set_modes(1'b1, 1'b1);
        send_item(CMD_SET_ABS, 32'd5000, 32'h0064_0000, 32'd256);
        send_item(CMD_TICK, 32'd5128, '0, '0);
        send_item(CMD_TICK, 32'd5256, '0, '0);                       // turn
        send_item(CMD_TICK, 32'd5300, '0, '0);                       // heading back
        send_item(CMD_TICK, 32'd5600, '0, '0);
        send_item(CMD_SET_REL, 32'd6000, 32'h0005_0000, '0);         // zero-length window
        send_item(CMD_TICK, 32'd6000, '0, '0);
        send_item(CMD_TICK, 32'd6001, '0, '0);

        // Random phases across all four mode settings
        drain_results();
        set_modes(1'b0, 1'b0);
        run_random_phase(150);

        drain_results();
        set_modes(1'b1, 1'b1);
        hold_request = 1;               // long receiver stall while commands keep coming
        run_random_phase(150);

        drain_results();
        set_modes(1'b0, 1'b1);
        run_random_phase(75);
        drain_results();                // sender pause until every result is back
        run_random_phase(75);

        drain_results();
        set_modes(1'b1, 1'b0);
        hold_request = 1;
        run_random_phase(150);

        drain_results();
        if (tracker.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> timed_position_ramp_unit.f
sv/tpr_pkg.sv
sv/tpr_alu.sv
sv/tpr_curve_rom.sv
sv/timed_position_ramp_unit.sv
tb/tb_timed_position_ramp_unit.sv
